// ===== rtl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg - shared types and constants of the order book matcher
// Book geometry, the resting entry record and the control bundle
// that the top level sends to every book cell.
// ----------------------------------------------------------------------------
`default_nettype none
package lobm_pkg;

  localparam int ORDERS_PER_SIDE = 16;
  localparam int PRODUCT_COUNT   = 16;
  localparam int SIDE_COUNT      = 2;

  localparam int BOOKS = PRODUCT_COUNT * SIDE_COUNT;
  localparam int PW    = (PRODUCT_COUNT > 1) ? $clog2(PRODUCT_COUNT) : 1;
  localparam int BW    = PW + 1;
  localparam int CW    = $clog2(ORDERS_PER_SIDE + 1);
  localparam int IW    = $clog2(ORDERS_PER_SIDE);

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic KIND_FILL    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [31:0] price;
    logic [31:0] volume;
    logic [15:0] account;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic          load;
    logic          shift;
    logic          wr_row;
    logic          wr_ins;
    logic          re;
    logic [BW-1:0] raddr;
    logic [BW-1:0] waddr;
    logic          side;
    entry_t        ins_entry;
  } cell_ctrl_t;

  // true when price a ranks strictly behind price b on this side
  function automatic logic worse(input logic side, input logic [31:0] a,
                                 input logic [31:0] b);
    return (side == SIDE_BUY) ? (a < b) : (a > b);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lobm_ram.sv =====
// ----------------------------------------------------------------------------
// lobm_ram - generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lobm_cell.sv =====
// ----------------------------------------------------------------------------
// lobm_cell - one book position across all books
// Stores one position of every book, holds a work copy that moves toward
// the head during the walk, and builds the shifted row for an insertion.
// ----------------------------------------------------------------------------
`default_nettype none
module lobm_cell
  import lobm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic       in_book_i,
  input  wire entry_t     next_entry_i,
  input  wire logic       next_valid_i,
  input  wire logic       app_i,
  input  wire entry_t     app_entry_i,
  input  wire entry_t     prev_rd_i,
  input  wire logic       prev_after_i,
  output entry_t          rd_o,
  output logic            after_o,
  output entry_t          w_o,
  output logic            wvalid_o
);

  entry_t rd;
  entry_t w_q, w_d;
  logic   wv_q, wv_d;
  entry_t r_q;
  entry_t ins;
  entry_t wdata;

  // per position storage, one word per book
  lobm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(BOOKS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ctrl_i.wr_row | ctrl_i.wr_ins),
    .waddr_i(ctrl_i.waddr),
    .wdata_i(wdata),
    .re_i   (ctrl_i.re),
    .raddr_i(ctrl_i.raddr),
    .rdata_o(rd)
  );

  // insertion: cells behind the new order take their neighbor's entry
  assign after_o = !in_book_i || worse(ctrl_i.side, rd.price, ctrl_i.ins_entry.price);
  assign ins     = after_o ? (prev_after_i ? prev_rd_i : ctrl_i.ins_entry) : rd;
  assign wdata   = ctrl_i.wr_ins ? ins : r_q;

  // work copy: load from storage or take the neighbor's entry
  always_comb begin
    w_d  = w_q;
    wv_d = wv_q;
    if (ctrl_i.load) begin
      w_d  = rd;
      wv_d = in_book_i;
    end else if (ctrl_i.shift) begin
      w_d  = next_entry_i;
      wv_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= 1'b0;
    end else begin
      wv_q <= wv_d;
    end
  end

  // payload registers: work copy and compacted row
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (app_i) begin
      r_q <= app_entry_i;
    end
  end

  assign rd_o     = rd;
  assign w_o      = w_q;
  assign wvalid_o = wv_q;

endmodule
`default_nettype wire

// ===== rtl/limit_order_book_matcher.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher - price-time priority limit order book
// Matches one limit order against the opposite book through a row of
// position cells, then rests any remainder in its own book if that book has room.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  order    | start / busy              | account, product, side, price, qty
//  result   | result_valid_o (strobe)   | kind, fill, price, account, flags
//
//  the time from accept to next accept is set by the walk that moves the
//  opposite book through the cell row one position a cycle; the insertion
//  step is skipped when nothing is left to rest; an order for an unknown
//  product goes straight to the summary.
//  reset clears the entry counts, so every book starts empty; no clearing pass.
//  results are strobed for one cycle each; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
module limit_order_book_matcher
  import lobm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] account_i,
  input  wire logic [3:0]  product_i,
  input  wire logic        side_i,
  input  wire logic [31:0] limit_price_i,
  input  wire logic [31:0] quantity_i,
  output logic             result_valid_o,
  output logic             kind_o,
  output logic [31:0]      fill_volume_o,
  output logic [31:0]      fill_price_o,
  output logic [15:0]      counter_account_o,
  output logic [31:0]      remaining_o,
  output logic             rested_o,
  output logic             book_full_o,
  output logic             last_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_WALK, ST_WB, ST_INS, ST_SUM
  } state_e;

  state_e        state_q;
  logic [15:0]   acct_q;
  logic          side_q;
  logic [31:0]   price_q;
  logic [31:0]   rem_q;
  logic [BW-1:0] opp_q, own_q;
  logic [CW-1:0] n_q, wp_q;
  logic [IW-1:0] step_q;
  logic          stop_q, rested_q, full_q;
  logic [CW-1:0] cnt_q [BOOKS];

  logic [7:0]    prod_ext;
  logic          prod_ok;
  logic [BW-1:0] in_opp, in_own, cnt_addr;
  logic [CW-1:0] cnt_rd;
  cell_ctrl_t    ctrl;

  entry_t        rd   [ORDERS_PER_SIDE];
  entry_t        w    [ORDERS_PER_SIDE];
  logic          wv   [ORDERS_PER_SIDE];
  logic          aft  [ORDERS_PER_SIDE];
  logic          inb  [ORDERS_PER_SIDE];
  logic          app  [ORDERS_PER_SIDE];

  entry_t        head, app_entry;
  logic          reach, do_fill, keep, blocked;
  logic [31:0]   fill, newvol;

  // book addresses of the incoming order
  assign prod_ext = 8'(product_i);
  assign prod_ok  = 9'(product_i) < 9'(PRODUCT_COUNT);
  assign in_opp   = {prod_ext[PW-1:0], ~side_i};
  assign in_own   = {prod_ext[PW-1:0], side_i};
  assign cnt_addr = (state_q == ST_IDLE) ? in_opp : own_q;
  assign cnt_rd   = cnt_q[cnt_addr];
  assign busy     = (state_q != ST_IDLE);

  // head cell decides fill, skip or stop
  assign head    = w[0];
  assign reach   = (side_q == SIDE_BUY) ? (price_q >= head.price)
                                        : (price_q <= head.price);
  assign blocked = wv[0] && (rem_q != 32'd0) && !stop_q && !reach;
  assign do_fill = wv[0] && (rem_q != 32'd0) && !stop_q && reach &&
                   (head.account != acct_q);
  assign fill    = (head.volume < rem_q) ? head.volume : rem_q;
  assign newvol  = head.volume - fill;
  assign keep    = wv[0] && !(do_fill && (newvol == 32'd0));

  always_comb begin
    app_entry        = head;
    app_entry.volume = do_fill ? newvol : head.volume;
  end

  // control bundle for the cell row
  always_comb begin
    ctrl           = '0;
    ctrl.load      = (state_q == ST_LOAD);
    ctrl.shift     = (state_q == ST_WALK);
    ctrl.wr_row    = (state_q == ST_WB);
    ctrl.wr_ins    = (state_q == ST_INS) && (n_q != CW'(ORDERS_PER_SIDE));
    ctrl.re        = (state_q == ST_IDLE) || (state_q == ST_WB);
    ctrl.raddr     = (state_q == ST_IDLE) ? in_opp : own_q;
    ctrl.waddr     = (state_q == ST_WB) ? opp_q : own_q;
    ctrl.side      = side_q;
    ctrl.ins_entry = '{price: price_q, volume: rem_q, account: acct_q};
  end

  // row of position cells
  for (genvar i = 0; i < ORDERS_PER_SIDE; i++) begin : g_cell
    assign inb[i] = CW'(i) < n_q;
    assign app[i] = (state_q == ST_WALK) && keep && (wp_q == CW'(i));
    if (i == 0) begin : g_first
      lobm_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .in_book_i   (inb[i]),
        .next_entry_i(w[i+1]),
        .next_valid_i(wv[i+1]),
        .app_i       (app[i]),
        .app_entry_i (app_entry),
        .prev_rd_i   ('0),
        .prev_after_i(1'b0),
        .rd_o        (rd[i]),
        .after_o     (aft[i]),
        .w_o         (w[i]),
        .wvalid_o    (wv[i])
      );
    end else if (i == ORDERS_PER_SIDE - 1) begin : g_last
      lobm_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .in_book_i   (inb[i]),
        .next_entry_i('0),
        .next_valid_i(1'b0),
        .app_i       (app[i]),
        .app_entry_i (app_entry),
        .prev_rd_i   (rd[i-1]),
        .prev_after_i(aft[i-1]),
        .rd_o        (rd[i]),
        .after_o     (aft[i]),
        .w_o         (w[i]),
        .wvalid_o    (wv[i])
      );
    end else begin : g_mid
      lobm_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .in_book_i   (inb[i]),
        .next_entry_i(w[i+1]),
        .next_valid_i(wv[i+1]),
        .app_i       (app[i]),
        .app_entry_i (app_entry),
        .prev_rd_i   (rd[i-1]),
        .prev_after_i(aft[i-1]),
        .rd_o        (rd[i]),
        .after_o     (aft[i]),
        .w_o         (w[i]),
        .wvalid_o    (wv[i])
      );
    end
  end

  // order payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      acct_q  <= account_i;
      side_q  <= side_i;
      price_q <= limit_price_i;
      opp_q   <= in_opp;
      own_q   <= in_own;
    end
  end

  // sequencer with registered result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      rem_q          <= '0;
      n_q            <= '0;
      wp_q           <= '0;
      step_q         <= '0;
      stop_q         <= 1'b0;
      rested_q       <= 1'b0;
      full_q         <= 1'b0;
      for (int b = 0; b < BOOKS; b++) begin
        cnt_q[b] <= '0;
      end
      result_valid_o    <= 1'b0;
      kind_o            <= KIND_FILL;
      fill_volume_o     <= '0;
      fill_price_o      <= '0;
      counter_account_o <= '0;
      remaining_o       <= '0;
      rested_o          <= 1'b0;
      book_full_o       <= 1'b0;
      last_o            <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            rem_q    <= quantity_i;
            n_q      <= cnt_rd;
            wp_q     <= '0;
            step_q   <= '0;
            stop_q   <= 1'b0;
            rested_q <= 1'b0;
            full_q   <= 1'b0;
            state_q  <= prod_ok ? ST_LOAD : ST_SUM;
          end
        end
        ST_LOAD: begin
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (blocked) begin
            stop_q <= 1'b1;
          end
          if (keep) begin
            wp_q <= wp_q + CW'(1);
          end
          if (do_fill) begin
            rem_q             <= rem_q - fill;
            result_valid_o    <= 1'b1;
            kind_o            <= KIND_FILL;
            fill_volume_o     <= fill;
            fill_price_o      <= head.price;
            counter_account_o <= head.account;
            remaining_o       <= rem_q - fill;
            rested_o          <= 1'b0;
            book_full_o       <= 1'b0;
            last_o            <= 1'b0;
          end
          step_q <= step_q + IW'(1);
          if (step_q == IW'(ORDERS_PER_SIDE - 1)) begin
            state_q <= ST_WB;
          end
        end
        ST_WB: begin
          cnt_q[opp_q] <= wp_q;
          n_q          <= cnt_rd;
          state_q      <= (rem_q != 32'd0) ? ST_INS : ST_SUM;
        end
        ST_INS: begin
          if (n_q == CW'(ORDERS_PER_SIDE)) begin
            full_q <= 1'b1;
          end else begin
            cnt_q[own_q] <= n_q + CW'(1);
            rested_q     <= 1'b1;
          end
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          result_valid_o    <= 1'b1;
          kind_o            <= KIND_SUMMARY;
          fill_volume_o     <= '0;
          fill_price_o      <= '0;
          counter_account_o <= '0;
          remaining_o       <= rem_q;
          rested_o          <= rested_q;
          book_full_o       <= full_q;
          last_o            <= 1'b1;
          state_q           <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
